FILE: rtl/core/sdm_pkg.sv
package sdm_pkg;

   // sample format
   localparam int SAMPLE_WIDTH_DEFAULT = 24;
   localparam int AXES = 3;

   // result field widths
   localparam int DIFF_BITS = 26;
   localparam int MEAN_BITS = 27;

   // clamped per-axis magnitude, saturates at 2^26
   localparam int MAG_BITS = 27;
   localparam logic [MAG_BITS-1:0] MAG_LIMIT = {1'b1, {(MAG_BITS-1){1'b0}}};
   localparam logic [DIFF_BITS-1:0] DIFF_MAX = {DIFF_BITS{1'b1}};

   // square, radicand and root chain widths
   localparam int SQ_BITS = 2 * MAG_BITS;
   localparam int ROOT_BITS = 28;
   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIMENSIONS  = 2'd0,
      CSR_MEAN_ENABLE = 2'd1
   } sdm_csr_index_type;

   localparam logic [1:0] DIM_2D = 2'd2;
   localparam logic [1:0] DIM_3D = 2'd3;
   localparam logic [1:0] DIMENSIONS_RESET = DIM_2D;
   localparam logic MEAN_ENABLE_RESET = 1'b1;

   typedef struct packed {
      logic [1:0] dimensions;
      logic       mean_enable;
   } sdm_cfg_type;

   // one item as it travels down the root chain
   typedef struct packed {
      logic [RAD_BITS-1:0]  rad_d;
      logic [RAD_BITS-1:0]  rad_s;
      logic [REM_BITS-1:0]  rem_d;
      logic [REM_BITS-1:0]  rem_s;
      logic [ROOT_BITS-1:0] root_d;
      logic [ROOT_BITS-1:0] root_s;
      logic                 one_d;
      logic                 neg_mean;
      logic                 mean_en;
   } sdm_cell_type;

endpackage

FILE: rtl/core/sdm_if.sv
interface sdm_req_if import sdm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] center_value;
   logic signed [SAMPLE_WIDTH-1:0] x_left;
   logic signed [SAMPLE_WIDTH-1:0] x_right;
   logic signed [SAMPLE_WIDTH-1:0] y_below;
   logic signed [SAMPLE_WIDTH-1:0] y_above;
   logic signed [SAMPLE_WIDTH-1:0] z_back;
   logic signed [SAMPLE_WIDTH-1:0] z_front;

   modport source (output valid, center_value, x_left, x_right, y_below, y_above,
                   z_back, z_front, input ready);
   modport sink (input valid, center_value, x_left, x_right, y_below, y_above,
                 z_back, z_front, output ready);
endinterface

interface sdm_rsp_if import sdm_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [DIFF_BITS-1:0]        difference_magnitude;
   logic signed [MEAN_BITS-1:0] local_mean;

   modport source (output valid, difference_magnitude, local_mean, input ready);
   modport sink (input valid, difference_magnitude, local_mean, output ready);
endinterface

interface sdm_csr_if import sdm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sdm_front.sv
module sdm_front import sdm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sdm_cfg_type                    cfg,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] center_value,
   input  logic signed [SAMPLE_WIDTH-1:0] x_left,
   input  logic signed [SAMPLE_WIDTH-1:0] x_right,
   input  logic signed [SAMPLE_WIDTH-1:0] y_below,
   input  logic signed [SAMPLE_WIDTH-1:0] y_above,
   input  logic signed [SAMPLE_WIDTH-1:0] z_back,
   input  logic signed [SAMPLE_WIDTH-1:0] z_front,
   output logic                           in_take,
   output logic                           out_valid,
   output sdm_cell_type                   out_item,
   input  logic                           out_take
);

   localparam int TW = SAMPLE_WIDTH + 2;
   localparam int AW = (TW > MAG_BITS) ? TW : MAG_BITS;

   function automatic logic [MAG_BITS-1:0] clamp_mag(input logic signed [TW-1:0] v);
      logic [TW-1:0] mag;
      logic [AW-1:0] ext;
      mag = v[TW-1] ? TW'(-v) : TW'(v);
      ext = AW'(mag);
      if (ext > AW'(MAG_LIMIT)) ext = AW'(MAG_LIMIT);
      return MAG_BITS'(ext);
   endfunction

   logic take_a, take_b, take_c, take_d;

   // stage a: second differences and sums
   logic                 a_valid_ff;
   logic signed [TW-1:0] a_d_ff [AXES];
   logic signed [TW-1:0] a_s_ff [AXES];
   logic signed [TW-1:0] a_d_in [AXES];
   logic signed [TW-1:0] a_s_in [AXES];
   logic                 a_use_y_ff, a_use_z_ff, a_mean_en_ff;
   logic                 a_use_y_in, a_use_z_in;
   logic signed [SAMPLE_WIDTH-1:0] lo [AXES];
   logic signed [SAMPLE_WIDTH-1:0] hi [AXES];
   logic signed [TW-1:0]           twice_c;

   // stage b: clamped magnitudes
   logic                b_valid_ff;
   logic [MAG_BITS-1:0] b_md_ff [AXES];
   logic [MAG_BITS-1:0] b_ms_ff [AXES];
   logic [MAG_BITS-1:0] b_md_in [AXES];
   logic [MAG_BITS-1:0] b_ms_in [AXES];
   logic                b_one_d_ff, b_neg_ff, b_mean_en_ff;
   logic                keep [AXES];

   // stage c: squares
   logic               c_valid_ff;
   logic [SQ_BITS-1:0] c_qd_ff [AXES];
   logic [SQ_BITS-1:0] c_qs_ff [AXES];
   logic [SQ_BITS-1:0] c_qd_in [AXES];
   logic [SQ_BITS-1:0] c_qs_in [AXES];
   logic               c_one_d_ff, c_neg_ff, c_mean_en_ff;

   // stage d: sums of squares
   logic         d_valid_ff;
   sdm_cell_type d_item_ff, d_item_in;

   // bubbles close up: a stage loads when empty or when it moves on
   assign take_d  = !d_valid_ff || out_take;
   assign take_c  = !c_valid_ff || take_d;
   assign take_b  = !b_valid_ff || take_c;
   assign take_a  = !a_valid_ff || take_b;
   assign in_take = take_a;

   always_comb begin
      lo[0] = x_left;
      hi[0] = x_right;
      lo[1] = y_below;
      hi[1] = y_above;
      lo[2] = z_back;
      hi[2] = z_front;
      twice_c = TW'(center_value) <<< 1;
      for (int a = 0; a < AXES; a++) begin
         a_d_in[a] = TW'(hi[a]) + TW'(lo[a]) - twice_c;
         a_s_in[a] = TW'(hi[a]) + TW'(lo[a]) + twice_c;
      end
      // dimensions zero behaves as 1-D
      a_use_y_in = (cfg.dimensions == DIM_2D) || (cfg.dimensions == DIM_3D);
      a_use_z_in = (cfg.dimensions == DIM_3D);
   end

   always_comb begin
      keep[0] = 1'b1;
      keep[1] = a_use_y_ff;
      keep[2] = a_use_z_ff;
      for (int a = 0; a < AXES; a++) begin
         b_md_in[a] = keep[a] ? clamp_mag(a_d_ff[a]) : '0;
         b_ms_in[a] = keep[a] ? clamp_mag(a_s_ff[a]) : '0;
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         c_qd_in[a] = b_md_ff[a] * b_md_ff[a];
         c_qs_in[a] = b_ms_ff[a] * b_ms_ff[a];
      end
   end

   always_comb begin
      d_item_in.rad_d    = RAD_BITS'(c_qd_ff[0]) + RAD_BITS'(c_qd_ff[1])
                         + RAD_BITS'(c_qd_ff[2]);
      d_item_in.rad_s    = RAD_BITS'(c_qs_ff[0]) + RAD_BITS'(c_qs_ff[1])
                         + RAD_BITS'(c_qs_ff[2]);
      d_item_in.rem_d    = '0;
      d_item_in.rem_s    = '0;
      d_item_in.root_d   = '0;
      d_item_in.root_s   = '0;
      d_item_in.one_d    = c_one_d_ff;
      d_item_in.neg_mean = c_neg_ff;
      d_item_in.mean_en  = c_mean_en_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (take_a) a_valid_ff <= in_valid;
         if (take_b) b_valid_ff <= a_valid_ff;
         if (take_c) c_valid_ff <= b_valid_ff;
         if (take_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take_a && in_valid) begin
         a_d_ff       <= a_d_in;
         a_s_ff       <= a_s_in;
         a_use_y_ff   <= a_use_y_in;
         a_use_z_ff   <= a_use_z_in;
         a_mean_en_ff <= cfg.mean_enable;
      end
      if (take_b && a_valid_ff) begin
         b_md_ff      <= b_md_in;
         b_ms_ff      <= b_ms_in;
         b_one_d_ff   <= !a_use_y_ff;
         b_neg_ff     <= a_s_ff[0][TW-1];
         b_mean_en_ff <= a_mean_en_ff;
      end
      if (take_c && b_valid_ff) begin
         c_qd_ff      <= c_qd_in;
         c_qs_ff      <= c_qs_in;
         c_one_d_ff   <= b_one_d_ff;
         c_neg_ff     <= b_neg_ff;
         c_mean_en_ff <= b_mean_en_ff;
      end
      if (take_d && c_valid_ff) begin
         d_item_ff <= d_item_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;

endmodule

FILE: rtl/core/sdm_root_cell.sv
module sdm_root_cell import sdm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sdm_cell_type in_item,
   output logic         in_take,
   output logic         out_valid,
   output sdm_cell_type out_item,
   input  logic         out_take
);

   // one restoring root digit: bring down two radicand bits, try root*4+1
   function automatic logic [REM_BITS+ROOT_BITS-1:0] root_step(
      input logic [REM_BITS-1:0]  rem,
      input logic [ROOT_BITS-1:0] root,
      input logic [1:0]           pair
   );
      logic [REM_BITS+1:0] cur;
      logic [REM_BITS+1:0] trial;
      cur   = {rem, pair};
      trial = (REM_BITS+2)'({root, 2'b01});
      if (cur >= trial) begin
         return {REM_BITS'(cur - trial), root[ROOT_BITS-2:0], 1'b1};
      end else begin
         return {REM_BITS'(cur), root[ROOT_BITS-2:0], 1'b0};
      end
   endfunction

   logic         valid_ff;
   sdm_cell_type item_ff, item_in;

   assign in_take = !valid_ff || out_take;

   always_comb begin
      item_in = in_item;
      {item_in.rem_d, item_in.root_d} =
         root_step(in_item.rem_d, in_item.root_d, in_item.rad_d[RAD_BITS-1 -: 2]);
      {item_in.rem_s, item_in.root_s} =
         root_step(in_item.rem_s, in_item.root_s, in_item.rad_s[RAD_BITS-1 -: 2]);
      item_in.rad_d = in_item.rad_d << 2;
      item_in.rad_s = in_item.rad_s << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/core/sdm_back.sv
module sdm_back import sdm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  sdm_cell_type                in_item,
   output logic                        in_take,
   output logic                        out_valid,
   output logic [DIFF_BITS-1:0]        difference_magnitude,
   output logic signed [MEAN_BITS-1:0] local_mean,
   input  logic                        out_ready
);

   logic                        valid_ff;
   logic [DIFF_BITS-1:0]        diff_ff, diff_in;
   logic signed [MEAN_BITS-1:0] mean_ff, mean_in;
   logic [DIFF_BITS-1:0]        mag_s;

   assign in_take = !valid_ff || out_ready;

   always_comb begin
      diff_in = (in_item.root_d > ROOT_BITS'(DIFF_MAX)) ? DIFF_MAX
                                                        : DIFF_BITS'(in_item.root_d);
      mag_s   = (in_item.root_s > ROOT_BITS'(DIFF_MAX)) ? DIFF_MAX
                                                        : DIFF_BITS'(in_item.root_s);
      if (!in_item.mean_en) begin
         mean_in = '0;
      end else if (in_item.one_d && in_item.neg_mean) begin
         // 1-D negative sum: root is the clamped magnitude, at most 2^26
         mean_in = -$signed(MEAN_BITS'(in_item.root_s));
      end else begin
         mean_in = $signed(MEAN_BITS'(mag_s));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         diff_ff <= diff_in;
         mean_ff <= mean_in;
      end
   end

   assign out_valid            = valid_ff;
   assign difference_magnitude = diff_ff;
   assign local_mean           = mean_ff;

endmodule

FILE: rtl/core/second_difference_magnitude_top.sv
// second difference magnitude of a 7-point stencil
//
// req_if: one item per cell, the centre value and its six axis neighbours,
//   signed samples; the y pair is ignored in 1-D mode, the z pair outside 3-D
// rsp_if: one item per request item, in order: difference_magnitude and
//   local_mean (signed sum in 1-D, else root of summed squares, 0 if disabled)
// csr_if: write-only, index 0 dimensions, index 1 mean_enable; always ready,
//   write only while no item is in flight
// pipeline: 4 front stages (stencil, clamp, square, sum), 28 root cells
//   (one root bit each), one output register
// throughput: one item per clock while rsp_if.ready is high; every cell and
//   stage holds one item and passes it on whenever the next one takes it
// reset: clears every valid bit, dimensions to 2 and mean_enable to 1;
//   the data registers are not cleared
// stall: while rsp_if.ready is low items collect in the chain, bubbles
//   closing up; req_if.ready drops only when all 33 stages are full
module second_difference_magnitude_top import sdm_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sdm_req_if.sink      req_if,
   sdm_rsp_if.source    rsp_if,
   sdm_csr_if.sink      csr_if
);

   // configuration registers
   sdm_cfg_type cfg_ff, cfg_in;

   // root chain links, element i feeds cell i
   logic         chain_valid [ROOT_BITS+1];
   sdm_cell_type chain_item  [ROOT_BITS+1];
   logic         chain_take  [ROOT_BITS+1];

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_DIMENSIONS:  cfg_in.dimensions  = csr_if.data[1:0];
            CSR_MEAN_ENABLE: cfg_in.mean_enable = csr_if.data[0];
            default: ;  // writes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dimensions  <= DIMENSIONS_RESET;
         cfg_ff.mean_enable <= MEAN_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stencil terms, clamping, squaring and summing
   sdm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_if.valid),
      .center_value (req_if.center_value),
      .x_left       (req_if.x_left),
      .x_right      (req_if.x_right),
      .y_below      (req_if.y_below),
      .y_above      (req_if.y_above),
      .z_back       (req_if.z_back),
      .z_front      (req_if.z_front),
      .in_take      (req_if.ready),
      .out_valid    (chain_valid[0]),
      .out_item     (chain_item[0]),
      .out_take     (chain_take[0])
   );

   // one cell per root bit, both roots side by side
   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
      sdm_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .in_take   (chain_take[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1]),
         .out_take  (chain_take[i+1])
      );
   end

   // saturation, sign and output register
   sdm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (chain_valid[ROOT_BITS]),
      .in_item              (chain_item[ROOT_BITS]),
      .in_take              (chain_take[ROOT_BITS]),
      .out_valid            (rsp_if.valid),
      .difference_magnitude (rsp_if.difference_magnitude),
      .local_mean           (rsp_if.local_mean),
      .out_ready            (rsp_if.ready)
   );

endmodule

FILE: rtl/core/sdm_checker.sv
module sdm_checker import sdm_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [DIFF_BITS-1:0]        difference_magnitude,
   input logic signed [MEAN_BITS-1:0] local_mean
);

   localparam logic signed [MEAN_BITS-1:0] MEAN_FLOOR = {1'b1, 1'b1, {(MEAN_BITS-2){1'b0}}};

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(difference_magnitude)
                                  && $stable(local_mean))
      else $error("stalled result changed or dropped");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a ready sink keeps the whole chain moving
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while result side ready");

   // only the 1-D path goes negative, no lower than minus 2^26; the check floors it at minus 2^25
   a_mean_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> local_mean >= MEAN_FLOOR)
      else $error("local mean below saturation floor");

endmodule

bind second_difference_magnitude_top sdm_checker u_sdm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .difference_magnitude (rsp_if.difference_magnitude),
   .local_mean           (rsp_if.local_mean)
);
